[rtl/core/mm4_pkg.sv]
// shared types and constants for the 4x4 fixed-point matrix multiplier
package mm4_pkg;

    localparam int ELEM_COUNT = 16;
    localparam int INDEX_BITS = 4;
    localparam int FIELD_BITS = 32;

    localparam logic [1:0] CMD_WRITE_LEFT  = 2'd0;
    localparam logic [1:0] CMD_WRITE_RIGHT = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY    = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic [INDEX_BITS-1:0]        elem_index;
        logic signed [FIELD_BITS-1:0] elem_value;
    } item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        out_index;
        logic signed [FIELD_BITS-1:0] out_value;
        logic                         saturated;
        logic                         last;
    } result_t;

    // travels alongside each multiply-accumulate step
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  done;
        logic [INDEX_BITS-1:0] pos;
    } mac_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

endpackage

[rtl/core/mm4_stream_if.sv]
// valid/ready stream channel carrying one payload per request
interface mm4_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/mm4_store.sv]
// 16-entry element memory with registered read, reads identity until written
module mm4_store #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [mm4_pkg::INDEX_BITS-1:0]       wr_addr,
    input  logic signed [WORD_BITS-1:0]          wr_data,
    input  logic                                 rd_en,
    input  logic [mm4_pkg::INDEX_BITS-1:0]       rd_addr,
    output logic signed [WORD_BITS-1:0]          rd_data
);

    localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1) << FRAC_BITS;

    logic signed [WORD_BITS-1:0]          mem [mm4_pkg::ELEM_COUNT];
    logic [mm4_pkg::ELEM_COUNT-1:0]       written_reg;
    logic signed [WORD_BITS-1:0]          rd_q_reg;
    logic                                 rd_written_reg;
    logic [mm4_pkg::INDEX_BITS-1:0]       rd_addr_reg;
    logic                                 rd_diag;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg       <= mem[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
            rd_addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // diagonal entries are column == row
    assign rd_diag = (rd_addr_reg[3:2] == rd_addr_reg[1:0]);
    assign rd_data = rd_written_reg ? rd_q_reg : (rd_diag ? ONE : '0);

endmodule

[rtl/core/mm4_mac.sv]
// shared multiplier, accumulator and shift/saturate, one product element at a time
module mm4_mac #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  mm4_pkg::mac_tag_t            tag,
    input  logic signed [WORD_BITS-1:0]  a,
    input  logic signed [WORD_BITS-1:0]  b,
    output logic                         res_valid,
    output mm4_pkg::result_t             res
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam logic signed [WORD_BITS-1:0] MAX_VAL = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

    mm4_pkg::mac_tag_t           tag2_reg;
    mm4_pkg::mac_tag_t           tag3_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [ACC_BITS-WORD_BITS:0] top_bits;
    logic                        sat;
    logic signed [WORD_BITS-1:0] val;

    assign prod_next = a * b;
    assign acc_next  = tag2_reg.first ? ACC_BITS'(prod_reg)
                                      : acc_reg + ACC_BITS'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag2_reg <= tag;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            if (tag2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // floor shift, then clip to the word range
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign top_bits = shifted[ACC_BITS-1:WORD_BITS-1];
    assign sat      = !((&top_bits) || !(|top_bits));
    assign val      = sat ? (shifted[ACC_BITS-1] ? MIN_VAL : MAX_VAL)
                          : shifted[WORD_BITS-1:0];

    assign res_valid     = tag3_reg.valid && tag3_reg.done;
    assign res.out_index = tag3_reg.pos;
    assign res.out_value = mm4_pkg::FIELD_BITS'(val);
    assign res.saturated = sat;
    assign res.last      = (&tag3_reg.pos);

endmodule

[rtl/core/matrix4x4_multiply.sv]
// 4x4 fixed-point matrix multiplier: a write request is accepted while idle and gives no result;
// a multiply request issues 64 multiply-accumulate steps, one per cycle while the output is not
// stalled, through a single shared multiplier fed by the two element memories, four steps per
// product element; no new request is taken until the last product element has been loaded
// into the output register
// reset is asynchronous active low; both stores then read as identity with no clearing pass
module matrix4x4_multiply #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    mm4_stream_if.sink          item,
    mm4_stream_if.source        product
);

    mm4_pkg::state_t             state_reg;
    mm4_pkg::state_t             state_next;
    logic [5:0]                  cnt_reg;
    logic [5:0]                  cnt_next;
    logic                        issuing;
    logic                        accept;
    logic                        adv;
    logic                        wr_left;
    logic                        wr_right;
    logic                        start;
    logic signed [WORD_BITS-1:0] wr_data;
    logic [1:0]                  k;
    logic [3:0]                  pos;
    logic [3:0]                  left_addr;
    logic [3:0]                  right_addr;
    mm4_pkg::mac_tag_t           tag0;
    mm4_pkg::mac_tag_t           tag1_reg;
    logic signed [WORD_BITS-1:0] left_data;
    logic signed [WORD_BITS-1:0] right_data;
    logic                        res_valid;
    mm4_pkg::result_t            res;
    logic                        res_load;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    mm4_pkg::result_t            out_reg;

    assign accept   = item.valid && item.ready;
    assign wr_left  = accept && (item.data.command == mm4_pkg::CMD_WRITE_LEFT);
    assign wr_right = accept && (item.data.command == mm4_pkg::CMD_WRITE_RIGHT);
    assign start    = accept && (item.data.command == mm4_pkg::CMD_MULTIPLY);
    assign wr_data  = WORD_BITS'(item.data.elem_value);

    // pipeline moves unless a finished result is blocked at the output
    assign adv      = !out_valid_reg || product.ready;
    assign res_load = res_valid && adv;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mm4_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mm4_pkg::ST_ISSUE;
                end
            end
            mm4_pkg::ST_ISSUE:
            begin
                if (adv && (&cnt_reg))
                begin
                    state_next = mm4_pkg::ST_DRAIN;
                end
            end
            mm4_pkg::ST_DRAIN:
            begin
                if (res_load && res.last)
                begin
                    state_next = mm4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mm4_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        issuing    = 1'b0;
        item.ready = 1'b0;
        unique case (state_reg)
            mm4_pkg::ST_IDLE:  item.ready = 1'b1;
            mm4_pkg::ST_ISSUE: issuing    = 1'b1;
            mm4_pkg::ST_DRAIN: issuing    = 1'b0;
            default:           issuing    = 1'b0;
        endcase
    end

    assign cnt_next = (issuing && adv) ? cnt_reg + 6'd1 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm4_pkg::ST_IDLE;
            cnt_reg   <= '0;
            tag1_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (adv)
            begin
                tag1_reg <= tag0;
            end
        end
    end

    // step counter is {column, row, k}
    assign pos        = cnt_reg[5:2];
    assign k          = cnt_reg[1:0];
    assign left_addr  = {k, pos[1:0]};
    assign right_addr = {pos[3:2], k};

    assign tag0.valid = issuing;
    assign tag0.first = (k == 2'd0);
    assign tag0.done  = (k == 2'd3);
    assign tag0.pos   = pos;

    mm4_store #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_left),
        .wr_addr (item.data.elem_index),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    mm4_store #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_right),
        .wr_addr (item.data.elem_index),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    mm4_mac #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tag       (tag1_reg),
        .a         (left_data),
        .b         (right_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    assign out_valid_next = res_load ? 1'b1 : (product.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign product.valid = out_valid_reg;
    assign product.data  = out_reg;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mm4_pkg::ST_IDLE) |-> !tag1_reg.valid)
        else $error("pipeline not empty while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.last) |=> (state_reg == mm4_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after last element");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !product.ready) |-> !res_load)
        else $error("result loaded over a pending one");
`endif

endmodule

[test/tb_matrix4x4_multiply.sv]
`timescale 1ns / 100ps
// self-checking testbench for the 4x4 fixed-point matrix multiplier under random flow control
module tb;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int ACC_BITS = 2 * WORD_BITS + 2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 300;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n;

    mm4_stream_if #(.payload_t(mm4_pkg::item_t)) item_ch ();
    mm4_stream_if #(.payload_t(mm4_pkg::result_t)) prod_ch ();

    matrix4x4_multiply #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .product(prod_ch)
    );

    logic signed [WORD_BITS-1:0] left_matrix [mm4_pkg::ELEM_COUNT];
    logic signed [WORD_BITS-1:0] right_matrix [mm4_pkg::ELEM_COUNT];
    mm4_pkg::item_t   pending_requests [$];
    mm4_pkg::result_t expected_products [$];
    int      request_total = 0;
    int      accepted_requests = 0;
    int      failures = 0;
    int      burst_left;
    int      gap_left;
    int      idle_cycles;
    logic [9:0] stall_phase;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic void apply_request(mm4_pkg::item_t req);
        logic signed [ACC_BITS-1:0]  acc;
        logic signed [ACC_BITS-1:0]  word_max;
        logic signed [ACC_BITS-1:0]  word_min;
        logic signed [WORD_BITS-1:0] clipped;
        mm4_pkg::result_t res;
        int pos;
        word_max = {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
        word_min = ~word_max;
        case (req.command)
            mm4_pkg::CMD_WRITE_LEFT:  left_matrix[req.elem_index] = req.elem_value;
            mm4_pkg::CMD_WRITE_RIGHT: right_matrix[req.elem_index] = req.elem_value;
            mm4_pkg::CMD_MULTIPLY:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        pos = c * 4 + r;
                        acc = '0;
                        for (int k = 0; k < 4; k++)
                        begin
                            acc = acc + left_matrix[k*4+r] * right_matrix[c*4+k];
                        end
                        acc = acc >>> FRAC_BITS;
                        res.saturated = 1'b1;
                        if (acc > word_max)
                        begin
                            clipped = word_max[WORD_BITS-1:0];
                        end
                        else if (acc < word_min)
                        begin
                            clipped = word_min[WORD_BITS-1:0];
                        end
                        else
                        begin
                            clipped = acc[WORD_BITS-1:0];
                            res.saturated = 1'b0;
                        end
                        res.out_index = 4'(pos);
                        res.out_value = clipped;
                        res.last = (pos == mm4_pkg::ELEM_COUNT - 1);
                        expected_products.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_product(mm4_pkg::result_t got);
        mm4_pkg::result_t want;
        if (expected_products.size() == 0)
        begin
            note_failure($sformatf(
                "unexpected product element: index %0d value %h sat %b last %b",
                got.out_index, got.out_value, got.saturated, got.last));
            return;
        end
        want = expected_products.pop_front();
        if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
            got.saturated !== want.saturated || got.last !== want.last)
        begin
            note_failure($sformatf(
                "product mismatch: expected index %0d value %h sat %b last %b, got %0d %h %b %b",
                want.out_index, want.out_value, want.saturated, want.last,
                got.out_index, got.out_value, got.saturated, got.last));
        end
    endfunction

    task automatic queue_request(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val);
        mm4_pkg::item_t req;
        req.command = cmd;
        req.elem_index = idx;
        req.elem_value = val;
        pending_requests.push_back(req);
        request_total++;
    endtask

    function automatic logic [31:0] random_elem_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            2, 3: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            4:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0001_0000;
                    default: v = 32'hFFFF_0000;
                endcase
            end
            default:
            begin
                v = $urandom() >> $urandom_range(1, 31);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                apply_request(item_ch.data);
                accepted_requests <= accepted_requests + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data <= pending_requests.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // product monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ch.ready <= 1'b0;
            stall_phase <= '0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[9:8])
                2'd0: prod_ch.ready <= 1'b1;
                2'd1: prod_ch.ready <= ($urandom_range(0, 1) == 1);
                2'd2: prod_ch.ready <= stall_phase[2];
                default: prod_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
            if (prod_ch.valid && prod_ch.ready)
            begin
                check_product(prod_ch.data);
            end
        end
    end

    // watchdog on cycles with no request and no product accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((item_ch.valid && item_ch.ready) || (prod_ch.valid && prod_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int counted;
        int writes;
        logic [1:0] cmd;
        rst_n = 1'b0;
        for (int i = 0; i < mm4_pkg::ELEM_COUNT; i++)
        begin
            left_matrix[i] = (i % 5 == 0) ? (1 <<< FRAC_BITS) : 0;
            right_matrix[i] = (i % 5 == 0) ? (1 <<< FRAC_BITS) : 0;
        end

        // identity times identity straight out of reset
        queue_request(mm4_pkg::CMD_MULTIPLY, 4'd0, 32'd0);
        // largest positive squared, min times max, min times min
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd0, 32'h7FFF_FFFF);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd0, 32'h7FFF_FFFF);
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd5, 32'h8000_0000);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd5, 32'h7FFF_FFFF);
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd15, 32'h8000_0000);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd15, 32'h8000_0000);
        // tiny negative product rounds toward minus infinity
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd10, 32'hFFFF_FFFF);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd10, 32'h0000_0001);
        queue_request(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF);
        queue_request(mm4_pkg::CMD_MULTIPLY, 4'd15, 32'hFFFF_FFFF);
        // exact limits without clipping at elements 0 and 5
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd0, 32'h0001_0000);
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd5, 32'h8000_0000);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd5, 32'h0001_0000);
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd3, 32'hFFFD_0000);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd12, 32'h0003_8000);
        queue_request(CMD_UNUSED, 4'd0, 32'h0000_0000);
        queue_request(mm4_pkg::CMD_MULTIPLY, 4'd9, 32'h5A5A_A5A5);
        queue_request(mm4_pkg::CMD_WRITE_LEFT, 4'd0, 32'h0000_0000);
        queue_request(mm4_pkg::CMD_WRITE_RIGHT, 4'd15, 32'h0000_0000);
        queue_request(mm4_pkg::CMD_MULTIPLY, 4'd6, 32'h8000_0000);

        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                writes = $urandom_range(0, 10);
                repeat (writes)
                begin
                    queue_request(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                        random_elem_value());
                end
                queue_request(mm4_pkg::CMD_MULTIPLY, 4'($urandom_range(0, 15)), $urandom());
                counted += writes + 1;
            end
            else
            begin
                cmd = 2'($urandom_range(0, 3));
                queue_request(cmd, 4'($urandom_range(0, 15)), random_elem_value());
                if (cmd != CMD_UNUSED)
                begin
                    counted++;
                end
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (accepted_requests < request_total) @(posedge clk);
        while (expected_products.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
